// ===== rtl/cssc_pkg.sv =====
// ----------------------------------------------------------------------------
// cssc_pkg
// Types and fixed constants for the cross stencil star counter: register
// indexes, register reset values, output field widths and the result item.
// ----------------------------------------------------------------------------
package cssc_pkg;

    localparam int CFG_INDEX_BITS = 2;
    localparam int CFG_DATA_BITS  = 11;

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        REG_IMAGE_WIDTH  = 2'd0,
        REG_IMAGE_HEIGHT = 2'd1,
        REG_SUM_LIMIT    = 2'd2
    } cfg_reg_t;

    localparam logic [CFG_DATA_BITS-1:0] WIDTH_RESET  = 11'd8;
    localparam logic [CFG_DATA_BITS-1:0] HEIGHT_RESET = 11'd6;
    localparam logic [CFG_DATA_BITS-1:0] LIMIT_RESET  = 11'd30;
    localparam logic [CFG_DATA_BITS-1:0] MAX_HEIGHT   = 11'd1024;
    localparam int                       MIN_DIM      = 3;

    localparam int ROW_BITS   = 10;
    localparam int COL_BITS   = 10;
    localparam int VALUE_BITS = 8;
    localparam int COUNT_BITS = 20;

    localparam logic [COUNT_BITS-1:0] COUNT_MAX = 20'hFFFFF;

    localparam int OUT_DEPTH    = 4;
    localparam int OUT_PTR_BITS = 2;
    localparam int OUT_CNT_BITS = 3;

    typedef struct packed {
        logic                  is_total;
        logic [ROW_BITS-1:0]   star_row;
        logic [COL_BITS-1:0]   star_col;
        logic [VALUE_BITS-1:0] star_value;
        logic [COUNT_BITS-1:0] star_count;
    } result_t;

endpackage

// ===== rtl/cross_stencil_star_counter_top.sv =====
// ----------------------------------------------------------------------------
// cross_stencil_star_counter_top
// Five-point star detector over a raster pixel stream, with a per-frame star
// count reported on the last pixel of each frame.
//
//   channel | direction | handshake            | payload
//   --------+-----------+----------------------+------------------------------
//   cfg     | in        | cfg_write            | cfg_index, cfg_data
//   in      | in        | in_valid / in_ready  | pixel
//   out     | out       | out_valid / out_ready| is_total, star_row, star_col,
//           |           |                      | star_value, star_count
//
// One pixel per cycle while in_ready is high. A pixel reads its column and
// the next one from the dual-read line store at accept and writes back
// in the cycle after. Results wait in a four-entry output queue; in_ready
// drops only when that queue cannot take the result of the next pixel. Reset
// clears control state at once; unwritten line store entries read as zero
// through a fill count, so there is no clearing pass.
// ----------------------------------------------------------------------------
module cross_stencil_star_counter_top
    import cssc_pkg::*;
#(
    parameter int MAX_WIDTH  = 1024,
    parameter int PIXEL_BITS = 8
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_write,
    input  logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [CFG_DATA_BITS-1:0]  cfg_data,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  logic [PIXEL_BITS-1:0]     pixel,
    output logic                      out_valid,
    input  logic                      out_ready,
    output logic                      is_total,
    output logic [ROW_BITS-1:0]       star_row,
    output logic [COL_BITS-1:0]       star_col,
    output logic [VALUE_BITS-1:0]     star_value,
    output logic [COUNT_BITS-1:0]     star_count
);

    localparam int AW = $clog2(MAX_WIDTH);
    localparam int HW = AW + 1;
    localparam int DW = (HW > CFG_DATA_BITS) ? HW : CFG_DATA_BITS;
    localparam int SW = PIXEL_BITS + 3;
    localparam int LW = (SW > CFG_DATA_BITS) ? SW : CFG_DATA_BITS;
    localparam int MW = 2 * PIXEL_BITS;

    logic [CFG_DATA_BITS-1:0] width_reg;
    logic [CFG_DATA_BITS-1:0] height_reg;
    logic [CFG_DATA_BITS-1:0] limit_reg;

    logic [HW-1:0]            w_eff;
    logic [CFG_DATA_BITS-1:0] h_eff;
    logic [DW-1:0]            width_wide;

    logic [AW-1:0]       col_reg;
    logic [ROW_BITS-1:0] row_reg;
    logic [COUNT_BITS-1:0] stars_reg;
    logic [COUNT_BITS-1:0] stars_next;
    logic [HW-1:0]       hw_reg;

    logic [HW-1:0]            col_plus1;
    logic [HW-1:0]            col_plus2;
    logic [CFG_DATA_BITS-1:0] row_plus1;
    logic                     row_end;
    logic                     frame_end;
    logic                     check;
    logic [AW-1:0]            addr_b;
    logic                     in_fire;

    logic [MW-1:0] line_mem [MAX_WIDTH];
    logic [MW-1:0] rd_a_reg;
    logic [MW-1:0] rd_b_reg;

    logic                  s1_valid_reg;
    logic [PIXEL_BITS-1:0] s1_px_reg;
    logic [AW-1:0]         s1_col_reg;
    logic [ROW_BITS-1:0]   s1_row_reg;
    logic                  s1_check_reg;
    logic                  s1_last_reg;
    logic                  s1_va_reg;
    logic                  s1_vb_reg;
    logic [PIXEL_BITS-1:0] left_reg;

    logic [PIXEL_BITS-1:0] centre;
    logic [PIXEL_BITS-1:0] up_px;
    logic [PIXEL_BITS-1:0] right_px;
    logic [SW-1:0]         sum;
    logic                  star;
    logic [COUNT_BITS-1:0] count_inc;
    logic [HW-1:0]         s1_col_plus1;
    logic [31:0]           col_wide;
    logic [31:0]           centre_wide;
    result_t               result;
    logic                  push;
    logic                  pop;

    result_t                 out_mem [OUT_DEPTH];
    logic [OUT_PTR_BITS-1:0] wr_ptr_reg;
    logic [OUT_PTR_BITS-1:0] rd_ptr_reg;
    logic [OUT_CNT_BITS-1:0] out_cnt_reg;
    result_t                 head;

    // configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= WIDTH_RESET;
            height_reg <= HEIGHT_RESET;
            limit_reg  <= LIMIT_RESET;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_IMAGE_WIDTH:  width_reg  <= cfg_data;
                REG_IMAGE_HEIGHT: height_reg <= cfg_data;
                REG_SUM_LIMIT:    limit_reg  <= cfg_data;
                default:          ;
            endcase
        end
    end

    assign width_wide = DW'(width_reg);

    always_comb
    begin
        if (width_wide < DW'(MIN_DIM))
            w_eff = HW'(MIN_DIM);
        else if (width_wide > DW'(MAX_WIDTH))
            w_eff = HW'(MAX_WIDTH);
        else
            w_eff = HW'(width_wide);

        if (height_reg < CFG_DATA_BITS'(MIN_DIM))
            h_eff = CFG_DATA_BITS'(MIN_DIM);
        else if (height_reg > MAX_HEIGHT)
            h_eff = MAX_HEIGHT;
        else
            h_eff = height_reg;
    end

    // position and stencil window decode
    assign col_plus1 = {1'b0, col_reg} + HW'(1);
    assign col_plus2 = col_plus1 + HW'(1);
    assign row_plus1 = CFG_DATA_BITS'(row_reg) + CFG_DATA_BITS'(1);
    assign row_end   = (col_plus1 >= w_eff);
    assign frame_end = row_end && (row_plus1 >= h_eff);
    assign check     = (row_reg >= ROW_BITS'(2)) && (col_reg != '0) && (col_plus2 <= w_eff);
    assign addr_b    = (col_reg == AW'(MAX_WIDTH - 1)) ? '0 : col_plus1[AW-1:0];

    assign in_ready = (out_cnt_reg + OUT_CNT_BITS'(s1_valid_reg))
                      <= OUT_CNT_BITS'(OUT_DEPTH - 1);
    assign in_fire  = in_valid && in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg      <= '0;
            row_reg      <= '0;
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= in_fire;
            if (in_fire)
            begin
                col_reg <= row_end ? '0 : col_plus1[AW-1:0];
                if (frame_end)
                    row_reg <= '0;
                else if (row_end)
                    row_reg <= row_plus1[ROW_BITS-1:0];
            end
        end
    end

    // line store: entry holds {row two back, row one back}
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            rd_a_reg <= line_mem[col_reg];
            rd_b_reg <= line_mem[addr_b];
        end
        if (s1_valid_reg)
            line_mem[s1_col_reg] <= {centre, s1_px_reg};
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_px_reg    <= pixel;
            s1_col_reg   <= col_reg;
            s1_row_reg   <= row_reg;
            s1_check_reg <= check;
            s1_last_reg  <= frame_end;
            s1_va_reg    <= ({1'b0, col_reg} < hw_reg);
            s1_vb_reg    <= (col_plus1 < hw_reg);
        end
        if (s1_valid_reg)
            left_reg <= centre;
    end

    // stencil sum and result
    assign centre   = s1_va_reg ? rd_a_reg[PIXEL_BITS-1:0] : '0;
    assign up_px    = s1_va_reg ? rd_a_reg[MW-1:PIXEL_BITS] : '0;
    assign right_px = s1_vb_reg ? rd_b_reg[PIXEL_BITS-1:0] : '0;
    assign sum      = SW'(left_reg) + SW'(centre) + SW'(right_px) + SW'(up_px) + SW'(s1_px_reg);
    assign star     = s1_check_reg && (LW'(sum) > LW'(limit_reg));

    assign count_inc    = (stars_reg < COUNT_MAX) ? stars_reg + COUNT_BITS'(1) : stars_reg;
    assign s1_col_plus1 = {1'b0, s1_col_reg} + HW'(1);
    assign col_wide     = 32'(s1_col_reg);
    assign centre_wide  = 32'(centre);

    always_comb
    begin
        result     = '0;
        stars_next = stars_reg;
        if (star)
        begin
            stars_next        = count_inc;
            result.is_total   = 1'b0;
            result.star_row   = s1_row_reg - ROW_BITS'(1);
            result.star_col   = col_wide[COL_BITS-1:0];
            result.star_value = centre_wide[VALUE_BITS-1:0];
            result.star_count = count_inc;
        end
        else if (s1_last_reg)
        begin
            result.is_total   = 1'b1;
            result.star_count = stars_reg;
        end
        if (s1_last_reg)
            stars_next = '0;
    end

    assign push = s1_valid_reg && (star || s1_last_reg);
    assign pop  = out_valid && out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stars_reg   <= '0;
            hw_reg      <= '0;
            wr_ptr_reg  <= '0;
            rd_ptr_reg  <= '0;
            out_cnt_reg <= '0;
        end
        else
        begin
            if (s1_valid_reg)
            begin
                stars_reg <= stars_next;
                if (s1_col_plus1 > hw_reg)
                    hw_reg <= s1_col_plus1;
            end
            if (push)
                wr_ptr_reg <= wr_ptr_reg + OUT_PTR_BITS'(1);
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + OUT_PTR_BITS'(1);
            out_cnt_reg <= out_cnt_reg + OUT_CNT_BITS'(push) - OUT_CNT_BITS'(pop);
        end
    end

    // output queue
    always_ff @(posedge clk)
    begin
        if (push)
            out_mem[wr_ptr_reg] <= result;
    end

    assign head       = out_mem[rd_ptr_reg];
    assign out_valid  = (out_cnt_reg != '0);
    assign is_total   = head.is_total;
    assign star_row   = head.star_row;
    assign star_col   = head.star_col;
    assign star_value = head.star_value;
    assign star_count = head.star_count;

    a_queue_room: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> (out_cnt_reg < OUT_CNT_BITS'(OUT_DEPTH)) || pop)
        else $error("result pushed into a full output queue");

    a_stage_follows_accept: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg |-> $past(in_fire))
        else $error("write-back stage active without an accepted item");

    a_fill_monotone: assert property (@(posedge clk) disable iff (!rst_n)
        $past(rst_n) |-> (hw_reg >= $past(hw_reg)))
        else $error("line store fill count went backward");

    a_total_fields_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && is_total) |->
            (star_row == '0) && (star_col == '0) && (star_value == '0))
        else $error("total report carries star position or value");

endmodule

// ===== bench/star_report_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// star_report_checker
// Watches the register port and both item channels of the star counter. Keeps
// its own copy of the registers, the two line stores and the frame position,
// works out the star and total reports that each accepted pixel causes, and
// compares every accepted result, field by field, with the oldest one due.
// ----------------------------------------------------------------------------
module star_report_checker
    import cssc_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_write,
    input  logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [CFG_DATA_BITS-1:0]  cfg_data,
    input  logic                      in_valid,
    input  logic                      in_ready,
    input  logic [VALUE_BITS-1:0]     pixel,
    input  logic                      out_valid,
    input  logic                      out_ready,
    input  logic                      is_total,
    input  logic [ROW_BITS-1:0]       star_row,
    input  logic [COL_BITS-1:0]       star_col,
    input  logic [VALUE_BITS-1:0]     star_value,
    input  logic [COUNT_BITS-1:0]     star_count,
    output int unsigned               reports_waiting,
    output int unsigned               mismatches
);

    localparam int LINE_DEPTH  = 1024;
    localparam int ROW_LIMIT   = 1024;

    logic [CFG_DATA_BITS-1:0] width_reg;
    logic [CFG_DATA_BITS-1:0] height_reg;
    logic [CFG_DATA_BITS-1:0] limit_reg;
    logic [VALUE_BITS-1:0]    upper_line [LINE_DEPTH];
    logic [VALUE_BITS-1:0]    centre_line [LINE_DEPTH];
    logic [ROW_BITS-1:0]      row_at;
    logic [COL_BITS-1:0]      col_at;
    logic [COUNT_BITS-1:0]    stars_in_frame;
    result_t                  reports_due [$];
    int unsigned              fault_count;

    function automatic int clamp_dim(input int value, input int ceiling);
        if (value < MIN_DIM)
            return MIN_DIM;
        if (value > ceiling)
            return ceiling;
        return value;
    endfunction

    task automatic note_fault(input string field, input int unsigned want, input int unsigned got);
        $display("%0t: %s expected %0d actual %0d", $time, field, want, got);
        fault_count++;
    endtask

    task automatic predict_pixel(input logic [VALUE_BITS-1:0] px);
        int      w;
        int      h;
        int      c;
        int      r;
        int      sum;
        bit      found;
        result_t rep;
        w     = clamp_dim(int'(width_reg), LINE_DEPTH);
        h     = clamp_dim(int'(height_reg), ROW_LIMIT);
        c     = int'(col_at);
        r     = int'(row_at);
        found = 1'b0;
        rep   = '0;
        if (r >= 2 && c >= 1 && c + 2 <= w)
        begin
            sum = int'(upper_line[c-1]) + int'(centre_line[c]) + int'(centre_line[c+1])
                + int'(upper_line[c]) + int'(px);
            if (sum > int'(limit_reg))
            begin
                if (stars_in_frame != COUNT_MAX)
                    stars_in_frame++;
                rep.is_total   = 1'b0;
                rep.star_row   = ROW_BITS'(r - 1);
                rep.star_col   = COL_BITS'(c);
                rep.star_value = centre_line[c];
                rep.star_count = stars_in_frame;
                reports_due.push_back(rep);
                found = 1'b1;
            end
        end
        upper_line[c]  = centre_line[c];
        centre_line[c] = px;
        if (c + 1 >= w)
        begin
            col_at = '0;
            if (r + 1 >= h)
            begin
                if (!found)
                begin
                    rep            = '0;
                    rep.is_total   = 1'b1;
                    rep.star_count = stars_in_frame;
                    reports_due.push_back(rep);
                end
                stars_in_frame = '0;
                row_at         = '0;
            end
            else
                row_at = ROW_BITS'(r + 1);
        end
        else
            col_at = COL_BITS'(c + 1);
    endtask

    task automatic check_report();
        result_t want;
        if (reports_due.size() == 0)
        begin
            $display("%0t: unexpected result total %0d row %0d col %0d value %0d count %0d",
                     $time, is_total, star_row, star_col, star_value, star_count);
            fault_count++;
        end
        else
        begin
            want = reports_due.pop_front();
            if (is_total !== want.is_total)
                note_fault("is_total", want.is_total, is_total);
            if (star_row !== want.star_row)
                note_fault("star_row", want.star_row, star_row);
            if (star_col !== want.star_col)
                note_fault("star_col", want.star_col, star_col);
            if (star_value !== want.star_value)
                note_fault("star_value", want.star_value, star_value);
            if (star_count !== want.star_count)
                note_fault("star_count", want.star_count, star_count);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg      = WIDTH_RESET;
            height_reg     = HEIGHT_RESET;
            limit_reg      = LIMIT_RESET;
            row_at         = '0;
            col_at         = '0;
            stars_in_frame = '0;
            fault_count    = 0;
            reports_due.delete();
            for (int i = 0; i < LINE_DEPTH; i++)
            begin
                upper_line[i]  = '0;
                centre_line[i] = '0;
            end
            reports_waiting <= 0;
            mismatches      <= 0;
        end
        else
        begin
            if (cfg_write)
            begin
                case (cfg_index)
                    REG_IMAGE_WIDTH:  width_reg  = cfg_data;
                    REG_IMAGE_HEIGHT: height_reg = cfg_data;
                    REG_SUM_LIMIT:    limit_reg  = cfg_data;
                    default:          ;
                endcase
            end
            if (out_valid && out_ready)
                check_report();
            if (in_valid && in_ready)
                predict_pixel(pixel);
            reports_waiting <= reports_due.size();
            mismatches      <= fault_count;
        end
    end

endmodule

// ===== bench/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Stimulus for the cross stencil star counter. Runs one frame on the reset
// registers, short directed frames on the smallest image around the sum limit
// edges, frames at the saturated image sizes, then random image sizes, limits
// and scenes with ragged frame ends. Both channels idle at random.
// ----------------------------------------------------------------------------
module tb;
    import cssc_pkg::*;

    localparam int STALL_LIMIT    = 4000;
    localparam int SETTLE_CYCLES  = 4;
    localparam int RANDOM_ITEMS   = 1600;
    localparam int IDLE_PERCENT   = 23;
    localparam int CALM_FROM      = 700;
    localparam int CALM_TO        = 1000;
    localparam int RESET_CYCLES   = 11;
    localparam int LINE_DEPTH     = 1024;

    localparam logic [CFG_INDEX_BITS-1:0] REG_UNUSED = 2'd3;

    typedef enum int {
        SCENE_NOISE,
        SCENE_SPARSE,
        SCENE_DIM,
        SCENE_BRIGHT,
        SCENE_DARK,
        SCENE_DOT
    } scene_t;

    logic                      clk       = 1'b0;
    logic                      rst_n     = 1'b0;
    logic                      cfg_write = 1'b0;
    logic [CFG_INDEX_BITS-1:0] cfg_index = '0;
    logic [CFG_DATA_BITS-1:0]  cfg_data  = '0;
    logic                      in_valid  = 1'b0;
    logic                      in_ready;
    logic [VALUE_BITS-1:0]     pixel     = '0;
    logic                      out_valid;
    logic                      out_ready = 1'b0;
    logic                      is_total;
    logic [ROW_BITS-1:0]       star_row;
    logic [COL_BITS-1:0]       star_col;
    logic [VALUE_BITS-1:0]     star_value;
    logic [COUNT_BITS-1:0]     star_count;
    logic                      calm      = 1'b0;
    int unsigned               reports_waiting;
    int unsigned               mismatches;
    int                        pixels_sent = 0;
    int                        quiet_cycles = 0;
    int                        random_start = 0;
    bit                        random_on    = 1'b0;

    cross_stencil_star_counter_top u_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_write  (cfg_write),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .pixel      (pixel),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .is_total   (is_total),
        .star_row   (star_row),
        .star_col   (star_col),
        .star_value (star_value),
        .star_count (star_count)
    );

    star_report_checker u_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_write       (cfg_write),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .pixel           (pixel),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .is_total        (is_total),
        .star_row        (star_row),
        .star_col        (star_col),
        .star_value      (star_value),
        .star_count      (star_count),
        .reports_waiting (reports_waiting),
        .mismatches      (mismatches)
    );

    always #6 clk = ~clk;

    always @(posedge clk)
        out_ready <= calm || ($urandom_range(99, 0) >= IDLE_PERCENT);

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) || cfg_write)
            quiet_cycles <= 0;
        else if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("== FAIL ==");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    task automatic push_pixel(input logic [VALUE_BITS-1:0] value);
        calm <= random_on && (pixels_sent - random_start >= CALM_FROM) &&
                (pixels_sent - random_start < CALM_TO);
        while (!calm && $urandom_range(99, 0) < IDLE_PERCENT)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        pixel    <= value;
        do
            @(posedge clk);
        while (!in_ready);
        pixels_sent++;
    endtask

    task automatic settle();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (reports_waiting != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_config(input logic [CFG_DATA_BITS-1:0] w,
                                input logic [CFG_DATA_BITS-1:0] h,
                                input logic [CFG_DATA_BITS-1:0] limit);
        cfg_write <= 1'b1;
        cfg_index <= REG_IMAGE_WIDTH;
        cfg_data  <= w;
        @(posedge clk);
        cfg_index <= REG_IMAGE_HEIGHT;
        cfg_data  <= h;
        @(posedge clk);
        cfg_index <= REG_SUM_LIMIT;
        cfg_data  <= limit;
        @(posedge clk);
        // unmapped index, must be dropped
        cfg_index <= REG_UNUSED;
        cfg_data  <= CFG_DATA_BITS'($urandom);
        @(posedge clk);
        cfg_write <= 1'b0;
    endtask

    function automatic logic [VALUE_BITS-1:0] scene_pixel(input scene_t scene, input int index);
        case (scene)
            SCENE_NOISE:  return VALUE_BITS'($urandom);
            SCENE_SPARSE: return ($urandom_range(9, 0) == 0) ?
                                 VALUE_BITS'($urandom_range(255, 128)) :
                                 VALUE_BITS'($urandom_range(7, 0));
            SCENE_DIM:    return VALUE_BITS'($urandom_range(12, 0));
            SCENE_BRIGHT: return '1;
            SCENE_DARK:   return '0;
            default:      return (index == 4) ? VALUE_BITS'(1) : VALUE_BITS'(0);
        endcase
    endfunction

    function automatic logic [CFG_DATA_BITS-1:0] pick_limit(input scene_t scene);
        int roll;
        roll = $urandom_range(99, 0);
        if (roll < 8)
            return '0;
        if (roll < 13)
            return CFG_DATA_BITS'(1275);
        if (roll < 20)
            return CFG_DATA_BITS'($urandom);
        case (scene)
            SCENE_NOISE:  return CFG_DATA_BITS'($urandom_range(850, 450));
            SCENE_SPARSE: return CFG_DATA_BITS'($urandom_range(400, 20));
            default:      return CFG_DATA_BITS'($urandom_range(45, 20));
        endcase
    endfunction

    task automatic run_phase(input logic [CFG_DATA_BITS-1:0] w,
                             input logic [CFG_DATA_BITS-1:0] h,
                             input logic [CFG_DATA_BITS-1:0] limit,
                             input scene_t scene,
                             input int frames,
                             input bit ragged);
        int span_w;
        int span_h;
        int total;
        span_w = (w < MIN_DIM) ? MIN_DIM : ((w > LINE_DEPTH) ? LINE_DEPTH : int'(w));
        span_h = (h < MIN_DIM) ? MIN_DIM : ((h > MAX_HEIGHT) ? int'(MAX_HEIGHT) : int'(h));
        total  = frames * span_w * span_h;
        if (ragged)
            total += $urandom_range(span_w * span_h - 1, 1);
        write_config(w, h, limit);
        for (int i = 0; i < total; i++)
            push_pixel(scene_pixel(scene, i));
        settle();
    endtask

    initial
    begin
        int                       roll;
        logic [CFG_DATA_BITS-1:0] w;
        logic [CFG_DATA_BITS-1:0] h;
        scene_t                   scene;

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset register values
        for (int i = 0; i < int'(WIDTH_RESET) * int'(HEIGHT_RESET); i++)
            push_pixel(scene_pixel(SCENE_DIM, i));
        settle();

        run_phase(11'd3, 11'd3, 11'd30, SCENE_BRIGHT, 1, 1'b0);
        run_phase(11'd3, 11'd3, 11'd1275, SCENE_BRIGHT, 1, 1'b0);
        run_phase(11'd3, 11'd3, 11'd1274, SCENE_BRIGHT, 1, 1'b0);
        run_phase(11'd3, 11'd3, 11'd0, SCENE_DARK, 1, 1'b0);
        run_phase(11'd3, 11'd3, 11'd0, SCENE_DOT, 1, 1'b0);

        // saturated image sizes
        run_phase(11'd0, 11'd0, 11'd150, SCENE_SPARSE, 1, 1'b0);
        run_phase(11'd2, 11'd1, 11'd30, SCENE_DIM, 2, 1'b1);

        random_start = pixels_sent;
        random_on    = 1'b1;
        while (pixels_sent < random_start + RANDOM_ITEMS)
        begin
            roll = $urandom_range(99, 0);
            if (roll < 5)
                w = CFG_DATA_BITS'($urandom_range(2, 0));
            else if (roll < 15)
                w = CFG_DATA_BITS'($urandom_range(40, 13));
            else
                w = CFG_DATA_BITS'($urandom_range(12, 3));
            h = ($urandom_range(9, 0) == 0) ? CFG_DATA_BITS'($urandom_range(2, 0)) :
                                             CFG_DATA_BITS'($urandom_range(8, 3));
            scene = scene_t'($urandom_range(int'(SCENE_DIM), int'(SCENE_NOISE)));
            run_phase(w, h, pick_limit(scene), scene, $urandom_range(3, 1),
                      $urandom_range(3, 0) == 0);
        end

        if (mismatches == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
